// ----- hdl/gtpb_pkg.sv -----
`timescale 1ns / 1ps
// gtpb_pkg: types, codes and fixed constants of the goertzel tone power bank
// used by gtpb_ctrl, gtpb_dp and goertzel_tone_power_bank_top; no dependencies
package gtpb_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int COEFF_BITS   = 18;
    localparam int COEFF_FRAC   = 16;
    localparam int POWER_BITS   = 64;
    localparam int BIN_BITS     = 3;
    localparam int CFG_COUNT    = 8;
    localparam int CFG_IDX_BITS = 3;
    // width of one multiplier digit, holds a coefficient magnitude in one step
    localparam int DIG_BITS     = 18;

    // 2cos(2*pi*f/fs) in Q2.16, element 0 is the 697 Hz bin
    localparam logic [CFG_COUNT-1:0][COEFF_BITS-1:0] COEFF_RESET = {
        18'd37257, 18'd52326, 18'd65330, 18'd76271,
        18'd96872, 18'd102803, 18'd107823, 18'd111911
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } smp_item_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]   tone_index;
        logic [POWER_BITS-1:0] tone_power;
        logic                  final_bin;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MSTEP,
        ST_MFIN,
        ST_POUT
    } state_t;

    // which product the shared multiplier forms, and what is done with it
    typedef enum logic [2:0] {
        PH_RECUR,
        PH_CD,
        PH_SQ1,
        PH_SQ2,
        PH_CROSS
    } phase_t;

    typedef struct packed {
        logic                take_sample;
        logic                mul_start;
        logic                mul_step;
        logic                mul_fin;
        phase_t              phase;
        logic                out_load;
        logic                final_bin;
        logic                clear_bins;
        logic [BIN_BITS-1:0] bin;
    } dp_cmd_t;

    typedef struct packed {
        logic last_sample;
        logic mul_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- hdl/goertzel_tone_power_bank_top.sv -----
`timescale 1ns / 1ps
// goertzel_tone_power_bank_top: eight-bin goertzel tone power detector
// depends on gtpb_pkg, gtpb_ctrl, gtpb_dp
//
// samples enter on smp_valid/smp_stall, one transaction per sample; the
// sample flagged block_end closes an analysis block. results leave on
// res_valid/res_stall, one transaction per bin in bin order, final_bin set
// on the last one, after which all bins are cleared.
// coefficients are written on cfg_we/cfg_index/cfg_data, by the user only while
// the block is idle: the block itself does not enforce it. reset loads the
// standard dtmf coefficients and clears every bin. one shared 18-bit-digit
// multiplier updates the bins one after another for each sample, and the
// block takes no new sample until it is through. on a block_end sample it
// then forms, bin by bin, c*d1, d1^2, d2^2 and the cross term, and loads
// each bin power into the result register.
// the result register holds a stalled result; the sequencer waits at the
// next result until it drains, and once the last result sits in the
// register the block takes the next sample.
module goertzel_tone_power_bank_top #(
    parameter int TONE_COUNT  = 8,
    parameter int DELAY_BITS  = 40,
    parameter int POWER_SHIFT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              smp_valid,
    output logic                              smp_stall,
    input  gtpb_pkg::smp_item_t               smp_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output gtpb_pkg::res_item_t               res_data,
    input  logic                              cfg_we,
    input  logic [gtpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [gtpb_pkg::COEFF_BITS-1:0]   cfg_data
);
    import gtpb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    gtpb_ctrl #(
        .TONE_COUNT (TONE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gtpb_dp #(
        .TONE_COUNT  (TONE_COUNT),
        .DELAY_BITS  (DELAY_BITS),
        .POWER_SHIFT (POWER_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- hdl/gtpb_ctrl.sv -----
`timescale 1ns / 1ps
// gtpb_ctrl: sequencer of the tone power bank, walks bins and multiplier phases
// depends on gtpb_pkg
module gtpb_ctrl #(
    parameter int TONE_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_stall,
    input  gtpb_pkg::dp_sts_t sts,
    output gtpb_pkg::dp_cmd_t cmd
);
    import gtpb_pkg::*;

    localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(TONE_COUNT - 1);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [BIN_BITS-1:0] bin_reg, bin_next;
    logic                bin_is_last;

    assign bin_is_last = (bin_reg == LAST_BIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_RECUR;
            bin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bin_reg   <= bin_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bin_next   = bin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (smp_valid)
                begin
                    state_next = ST_MLOAD;
                    phase_next = PH_RECUR;
                    bin_next   = '0;
                end
            end
            ST_MLOAD:
            begin
                state_next = ST_MSTEP;
            end
            ST_MSTEP:
            begin
                if (sts.mul_last)
                begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN:
            begin
                case (phase_reg)
                    PH_RECUR:
                    begin
                        if (!bin_is_last)
                        begin
                            bin_next   = bin_reg + BIN_BITS'(1);
                            state_next = ST_MLOAD;
                        end
                        else if (sts.last_sample)
                        begin
                            bin_next   = '0;
                            phase_next = PH_CD;
                            state_next = ST_MLOAD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_CD:
                    begin
                        phase_next = PH_SQ1;
                        state_next = ST_MLOAD;
                    end
                    PH_SQ1:
                    begin
                        phase_next = PH_SQ2;
                        state_next = ST_MLOAD;
                    end
                    PH_SQ2:
                    begin
                        phase_next = PH_CROSS;
                        state_next = ST_MLOAD;
                    end
                    PH_CROSS:
                    begin
                        state_next = ST_POUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POUT:
            begin
                if (sts.out_free)
                begin
                    if (bin_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bin_next   = bin_reg + BIN_BITS'(1);
                        phase_next = PH_CD;
                        state_next = ST_MLOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        smp_stall       = (state_reg != ST_IDLE);
        cmd.take_sample = (state_reg == ST_IDLE) && smp_valid;
        cmd.mul_start   = (state_reg == ST_MLOAD);
        cmd.mul_step    = (state_reg == ST_MSTEP);
        cmd.mul_fin     = (state_reg == ST_MFIN);
        cmd.phase       = phase_reg;
        cmd.bin         = bin_reg;
        cmd.final_bin   = bin_is_last;
        cmd.out_load    = (state_reg == ST_POUT) && sts.out_free;
        cmd.clear_bins  = (state_reg == ST_POUT) && sts.out_free && bin_is_last;
    end

endmodule

// ----- hdl/gtpb_dp.sv -----
`timescale 1ns / 1ps
// gtpb_dp: bin state, coefficient registers, digit-serial multiplier, power
// accumulator and result register; depends on gtpb_pkg
module gtpb_dp #(
    parameter int TONE_COUNT  = 8,
    parameter int DELAY_BITS  = 40,
    parameter int POWER_SHIFT = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gtpb_pkg::smp_item_t                  smp_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output gtpb_pkg::res_item_t                  res_data,
    input  logic                                 cfg_we,
    input  logic [gtpb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [gtpb_pkg::COEFF_BITS-1:0]      cfg_data,
    input  gtpb_pkg::dp_cmd_t                    cmd,
    output gtpb_pkg::dp_sts_t                    sts
);
    import gtpb_pkg::*;

    localparam int DB        = DELAY_BITS;
    localparam int IDX_BITS  = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1;
    localparam int ND_D      = (DB + DIG_BITS - 1) / DIG_BITS;
    localparam int TB        = DB + COEFF_BITS;
    localparam int TMAG_BITS = TB - 1;
    localparam int ND_T      = (TMAG_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int BW        = ND_T * DIG_BITS;
    localparam int PW        = 2 * DB + 16;
    localparam int SPW       = PW + 1;
    localparam int RW        = SPW + 1;
    localparam int ACC_BITS  = 2 * DB + 18;
    localparam int CNT_BITS  = $clog2(ND_T + 1);
    localparam int PSH       = COEFF_FRAC + POWER_SHIFT;
    localparam int SH_C      = DIG_BITS * (ND_T - 1);
    localparam int SH_D      = DIG_BITS * (ND_T - ND_D);

    logic [COEFF_BITS-1:0]         coeff_reg [CFG_COUNT];
    logic signed [DB-1:0]          d1_reg [TONE_COUNT];
    logic signed [DB-1:0]          d2_reg [TONE_COUNT];

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          last_reg, last_next;
    logic [DB-1:0]                 a_reg, a_next;
    logic [BW-1:0]                 b_reg, b_next;
    logic [PW-1:0]                 prod_reg, prod_next;
    logic                          neg_reg, neg_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic signed [TB-1:0]          cross_reg, cross_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic                          res_valid_reg, res_valid_next;
    res_item_t                     res_reg, res_next;

    logic [IDX_BITS-1:0]           bidx;
    logic signed [COEFF_BITS-1:0]  c_sel;
    logic signed [DB-1:0]          d1_sel, d2_sel;
    logic [COEFF_BITS-1:0]         c_mag;
    logic [DB-1:0]                 d1_mag, d2_mag;
    logic [TB-1:0]                 t_mag;
    logic [DIG_BITS-1:0]           digit;
    logic [DB+DIG_BITS-1:0]        pp;
    logic [PW-1:0]                 prod_step;
    logic signed [SPW-1:0]         sprod, scaled;
    logic signed [RW-1:0]          rsum;
    logic [RW-DB:0]                rsum_hi;
    logic signed [DB-1:0]          recur_next;
    logic signed [ACC_BITS-1:0]    sq_term, pshift;
    logic [POWER_BITS-1:0]         power;

    assign bidx   = cmd.bin[IDX_BITS-1:0];
    assign c_sel  = signed'(coeff_reg[cmd.bin]);
    assign d1_sel = d1_reg[bidx];
    assign d2_sel = d2_reg[bidx];

    assign c_mag  = c_sel[COEFF_BITS-1] ? (~c_sel + COEFF_BITS'(1)) : c_sel;
    assign d1_mag = d1_sel[DB-1] ? (~d1_sel + DB'(1)) : d1_sel;
    assign d2_mag = d2_sel[DB-1] ? (~d2_sel + DB'(1)) : d2_sel;
    assign t_mag  = cross_reg[TB-1] ? (~cross_reg + TB'(1)) : cross_reg;

    // msb-first digit step: prod = prod * 2^DIG + a * digit
    assign digit     = b_reg[BW-1 -: DIG_BITS];
    assign pp        = a_reg * digit;
    assign prod_step = (prod_reg << DIG_BITS) + PW'(pp);

    assign sprod = neg_reg ? -signed'({1'b0, prod_reg}) : signed'({1'b0, prod_reg});

    // recurrence: floor(c*d1 / 2^16) + x - d2, saturated to the delay width
    assign scaled  = sprod >>> COEFF_FRAC;
    assign rsum    = RW'(scaled) + RW'(x_reg) - RW'(d2_sel);
    assign rsum_hi = rsum[RW-1:DB-1];

    always_comb
    begin
        if ((&rsum_hi) || !(|rsum_hi))
        begin
            recur_next = rsum[DB-1:0];
        end
        else if (rsum[RW-1])
        begin
            recur_next = {1'b1, {(DB-1){1'b0}}};
        end
        else
        begin
            recur_next = {1'b0, {(DB-1){1'b1}}};
        end
    end

    assign sq_term = signed'(ACC_BITS'({prod_reg, {COEFF_FRAC{1'b0}}}));
    assign pshift  = acc_reg >>> PSH;

    always_comb
    begin
        if (pshift[ACC_BITS-1])
        begin
            power = '0;
        end
        else if (|pshift[ACC_BITS-1:POWER_BITS])
        begin
            power = '1;
        end
        else
        begin
            power = pshift[POWER_BITS-1:0];
        end
    end

    // multiplier load and steps
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        if (cmd.mul_start)
        begin
            prod_next = '0;
            case (cmd.phase)
                PH_RECUR, PH_CD:
                begin
                    a_next   = d1_mag;
                    b_next   = BW'(c_mag) << SH_C;
                    neg_next = c_sel[COEFF_BITS-1] ^ d1_sel[DB-1];
                    cnt_next = CNT_BITS'(1);
                end
                PH_SQ1:
                begin
                    a_next   = d1_mag;
                    b_next   = BW'(d1_mag) << SH_D;
                    neg_next = 1'b0;
                    cnt_next = CNT_BITS'(ND_D);
                end
                PH_SQ2:
                begin
                    a_next   = d2_mag;
                    b_next   = BW'(d2_mag) << SH_D;
                    neg_next = 1'b0;
                    cnt_next = CNT_BITS'(ND_D);
                end
                PH_CROSS:
                begin
                    a_next   = d2_mag;
                    b_next   = BW'(t_mag[TMAG_BITS-1:0]);
                    neg_next = cross_reg[TB-1] ^ d2_sel[DB-1];
                    cnt_next = CNT_BITS'(ND_T);
                end
                default:
                begin
                    a_next   = '0;
                    b_next   = '0;
                    neg_next = 1'b0;
                    cnt_next = CNT_BITS'(1);
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            b_next    = b_reg << DIG_BITS;
            prod_next = prod_step;
            cnt_next  = cnt_reg - CNT_BITS'(1);
        end
    end

    // power terms: 2^16*(d1^2 + d2^2) - (c*d1)*d2
    always_comb
    begin
        cross_next = cross_reg;
        acc_next   = acc_reg;
        if (cmd.mul_fin)
        begin
            case (cmd.phase)
                PH_CD:    cross_next = sprod[TB-1:0];
                PH_SQ1:   acc_next   = sq_term;
                PH_SQ2:   acc_next   = acc_reg + sq_term;
                PH_CROSS: acc_next   = acc_reg - ACC_BITS'(sprod);
                default:  acc_next   = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        x_next    = x_reg;
        last_next = last_reg;
        if (cmd.take_sample)
        begin
            x_next    = smp_data.sample;
            last_next = smp_data.block_end;
        end
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (cmd.out_load)
        begin
            res_next.tone_index = cmd.bin;
            res_next.tone_power = power;
            res_next.final_bin  = cmd.final_bin;
            res_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        last_reg  <= last_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        cross_reg <= cross_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                coeff_reg[i] <= COEFF_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            coeff_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TONE_COUNT; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (cmd.clear_bins)
        begin
            for (int i = 0; i < TONE_COUNT; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (cmd.mul_fin && (cmd.phase == PH_RECUR))
        begin
            d2_reg[bidx] <= d1_sel;
            d1_reg[bidx] <= recur_next;
        end
    end

    assign sts.last_sample = last_reg;
    assign sts.mul_last    = (cnt_reg == CNT_BITS'(1));
    assign sts.out_free    = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ----- tb/gtpb_power_checker.sv -----
`timescale 1ns / 1ps
// gtpb_power_checker: watches the sample, coefficient and result ports of the
// goertzel tone power bank, predicts every bin power and compares in order
// depends on gtpb_pkg
module gtpb_power_checker #(
    parameter int TONE_COUNT  = 8,
    parameter int DELAY_BITS  = 40,
    parameter int POWER_SHIFT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              smp_valid,
    input  logic                              smp_stall,
    input  gtpb_pkg::smp_item_t               smp_data,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  gtpb_pkg::res_item_t               res_data,
    input  logic                              cfg_we,
    input  logic [gtpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [gtpb_pkg::COEFF_BITS-1:0]   cfg_data,
    output int                                fail_count,
    output int                                powers_owed,
    output int                                powers_checked
);
    import gtpb_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam wide_t DELAY_MAX = (wide_t'(1) <<< (DELAY_BITS - 1)) - 1;
    localparam wide_t DELAY_MIN = -(wide_t'(1) <<< (DELAY_BITS - 1));

    logic signed [COEFF_BITS-1:0] coef [CFG_COUNT];
    logic signed [DELAY_BITS-1:0] dly1 [TONE_COUNT];
    logic signed [DELAY_BITS-1:0] dly2 [TONE_COUNT];
    res_item_t                    owed_powers [$];

    // one goertzel step: x + floor(c*d1 / 2^16) - d2, clamped to the delay width
    function automatic logic signed [DELAY_BITS-1:0] goertzel_step(
        input logic signed [COEFF_BITS-1:0]  c,
        input logic signed [DELAY_BITS-1:0]  d1,
        input logic signed [DELAY_BITS-1:0]  d2,
        input logic signed [SAMPLE_BITS-1:0] x
    );
        wide_t acc;
        acc = wide_t'(c) * wide_t'(d1);
        acc = acc >>> COEFF_FRAC;
        acc = acc + wide_t'(x) - wide_t'(d2);
        if (acc > DELAY_MAX)
        begin
            acc = DELAY_MAX;
        end
        else if (acc < DELAY_MIN)
        begin
            acc = DELAY_MIN;
        end
        return acc[DELAY_BITS-1:0];
    endfunction

    // d1^2 + d2^2 - c*d1*d2 at full width, scaled down, clamped at zero and saturated
    function automatic logic [POWER_BITS-1:0] bin_power(
        input logic signed [COEFF_BITS-1:0] c,
        input logic signed [DELAY_BITS-1:0] d1,
        input logic signed [DELAY_BITS-1:0] d2
    );
        wide_t w1;
        wide_t w2;
        wide_t p;
        w1 = wide_t'(d1);
        w2 = wide_t'(d2);
        p  = ((w1 * w1 + w2 * w2) <<< COEFF_FRAC) - wide_t'(c) * w1 * w2;
        p  = p >>> (COEFF_FRAC + POWER_SHIFT);
        if (p < 0)
        begin
            return '0;
        end
        if (p[127:POWER_BITS] != '0)
        begin
            return '1;
        end
        return p[POWER_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t                    want;
        logic signed [DELAY_BITS-1:0] nxt;
        int                           b;
        if (!rst_n)
        begin
            for (b = 0; b < CFG_COUNT; b++)
            begin
                coef[b] = COEFF_RESET[b];
            end
            for (b = 0; b < TONE_COUNT; b++)
            begin
                dly1[b] = '0;
                dly2[b] = '0;
            end
            owed_powers.delete();
            fail_count     = 0;
            powers_owed    = 0;
            powers_checked = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                powers_checked++;
                if (owed_powers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with nothing owed: bin %0d power %0d final %0b",
                                 $realtime, res_data.tone_index, res_data.tone_power,
                                 res_data.final_bin);
                    end
                end
                else
                begin
                    want = owed_powers.pop_front();
                    if (want !== res_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: power mismatch: want bin %0d power %0d final %0b",
                                     $realtime, want.tone_index, want.tone_power,
                                     want.final_bin);
                            $display("%0t:                  got bin %0d power %0d final %0b",
                                     $realtime, res_data.tone_index, res_data.tone_power,
                                     res_data.final_bin);
                        end
                    end
                end
            end

            // a 3-bit index always lands on one of the eight registers
            if (cfg_we)
            begin
                coef[cfg_index] = cfg_data;
            end

            if (smp_valid && !smp_stall)
            begin
                for (b = 0; b < TONE_COUNT; b++)
                begin
                    nxt     = goertzel_step(coef[b], dly1[b], dly2[b], smp_data.sample);
                    dly2[b] = dly1[b];
                    dly1[b] = nxt;
                end
                if (smp_data.block_end)
                begin
                    for (b = 0; b < TONE_COUNT; b++)
                    begin
                        want.tone_index = BIN_BITS'(b);
                        want.tone_power = bin_power(coef[b], dly1[b], dly2[b]);
                        want.final_bin  = (b == TONE_COUNT - 1);
                        owed_powers.push_back(want);
                    end
                    for (b = 0; b < TONE_COUNT; b++)
                    begin
                        dly1[b] = '0;
                        dly2[b] = '0;
                    end
                end
            end
            powers_owed = owed_powers.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for goertzel_tone_power_bank_top; prediction and
// comparison live in gtpb_power_checker. depends on gtpb_pkg and the rtl
module tb_top;

    import gtpb_pkg::*;

    localparam int TONE_COUNT   = 8;
    localparam int DELAY_BITS   = 40;
    localparam int POWER_SHIFT  = 16;
    localparam int RANDOM_ITEMS = 210;
    localparam int PHASE_COUNT  = 6;
    // this covers any leftover work of the bank after the last owed power is back
    localparam int SETTLE_CYCLES = 40;
    localparam int PUMP_SAMPLES  = 22;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    localparam logic [COEFF_BITS-1:0]         COEFF_TOP    = 18'h1FFFF;
    localparam logic [COEFF_BITS-1:0]         COEFF_BOTTOM = 18'h20000;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX      = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN      = 16'sh8000;

    logic                    clk;
    logic                    rst_n;
    logic                    smp_valid;
    logic                    smp_stall;
    smp_item_t               smp_data;
    logic                    res_valid;
    logic                    res_stall;
    res_item_t               res_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COEFF_BITS-1:0]   cfg_data;

    int fail_count;
    int powers_owed;
    int powers_checked;
    int samples_sent;
    int blocks_sent;
    int burst_left;
    bit idling_on;

    goertzel_tone_power_bank_top #(
        .TONE_COUNT  (TONE_COUNT),
        .DELAY_BITS  (DELAY_BITS),
        .POWER_SHIFT (POWER_SHIFT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gtpb_power_checker #(
        .TONE_COUNT  (TONE_COUNT),
        .DELAY_BITS  (DELAY_BITS),
        .POWER_SHIFT (POWER_SHIFT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .smp_valid      (smp_valid),
        .smp_stall      (smp_stall),
        .smp_data       (smp_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_data       (res_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .powers_owed    (powers_owed),
        .powers_checked (powers_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: stretches of no stall, random stall and periodic long stalls
    initial
    begin
        int mode;
        int span;
        int period;
        int k;
        res_stall = 1'b0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 40);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: res_stall = 1'b0;
                    1: res_stall = ($urandom_range(0, 99) < 30);
                    2: res_stall = ($urandom_range(0, 99) < 75);
                    default: res_stall = ((k / period) % 2 == 1);
                endcase
            end
        end
    end

    // one sample transaction; valid stays up when the next one follows in the burst
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        int gap;
        smp_data.sample    = s;
        smp_data.block_end = last;
        smp_valid          = 1'b1;
        do @(posedge clk); while (smp_stall);
        @(negedge clk);
        samples_sent++;
        if (last)
        begin
            blocks_sent++;
        end
        if (idling_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 10);
                gap        = $urandom_range(1, 35);
                smp_valid  = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // hold off until every owed power is back and the bank has gone quiet
    task automatic settle_bank();
        smp_valid = 1'b0;
        while (powers_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_coeff(input int idx, input logic [COEFF_BITS-1:0] val);
        smp_valid = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = CFG_IDX_BITS'(idx);
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        int                           phase;
        int                           quota;
        int                           n;
        int                           k;
        int                           b;
        int                           blk_len;
        int                           mode;
        int                           half;
        int                           amp;
        logic signed [SAMPLE_BITS-1:0] s;
        logic [COEFF_BITS-1:0]        coeff_set [CFG_COUNT];

        rst_n      = 1'b0;
        smp_valid  = 1'b0;
        smp_data   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idling_on  = 1'b0;
        burst_left = 0;
        samples_sent = 0;
        blocks_sent  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset coefficients: silent block, lone extremes, nyquist square at full scale
        send_sample(16'sd0, 1'b1);
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        for (k = 0; k < 4; k++)
        begin
            send_sample((k % 2 == 0) ? SMP_MAX : SMP_MIN, k == 3);
        end
        settle_bank();

        // flipping each coefficient between +2 and -2 every sample grows the
        // delays geometrically, so they hit the delay saturation within the block
        for (n = 0; n < PUMP_SAMPLES; n++)
        begin
            for (b = 0; b < CFG_COUNT; b++)
            begin
                write_coeff(b, ((n % 2 == 0) == (b < 4)) ? COEFF_TOP : COEFF_BOTTOM);
            end
            send_sample(SMP_MAX, n == PUMP_SAMPLES - 1);
            settle_bank();
        end

        quota = RANDOM_ITEMS / PHASE_COUNT;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            for (b = 0; b < CFG_COUNT; b++)
            begin
                case (phase)
                    0: coeff_set[b] = COEFF_RESET[b];
                    1: coeff_set[b] = COEFF_BITS'($urandom);
                    2: coeff_set[b] = COEFF_TOP;
                    3: coeff_set[b] = COEFF_BOTTOM;
                    4: coeff_set[b] = '0;
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: coeff_set[b] = COEFF_TOP;
                            1: coeff_set[b] = COEFF_BOTTOM;
                            default: coeff_set[b] = COEFF_BITS'($urandom);
                        endcase
                    end
                endcase
                write_coeff(b, coeff_set[b]);
            end

            // one phase runs back to back with no sender gaps
            idling_on  = (phase != 2);
            burst_left = 0;
            n = 0;
            while (n < quota)
            begin
                blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
                mode = $urandom_range(0, 3);
                half = $urandom_range(1, 6);
                amp  = $urandom_range(0, 32767);
                for (k = 0; k < blk_len; k++)
                begin
                    case (mode)
                        0: s = SAMPLE_BITS'($urandom);
                        1: s = ((k / half) % 2 == 1) ? SAMPLE_BITS'(-amp) : SAMPLE_BITS'(amp);
                        2: s = ($urandom_range(0, 1) == 1) ? SMP_MAX : SMP_MIN;
                        default: s = SAMPLE_BITS'($urandom_range(0, 15) - 8);
                    endcase
                    send_sample(s, k == blk_len - 1);
                    n++;
                end
                // now and then wait for the whole block of powers before going on
                if ($urandom_range(0, 9) == 0)
                begin
                    smp_valid = 1'b0;
                    while (powers_owed != 0) @(negedge clk);
                end
            end
            settle_bank();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("run covered %0d samples in %0d analysis blocks, %0d bin powers checked",
                 samples_sent, blocks_sent, powers_checked);
        $display("coefficient sets: dtmf default, alternating +-2 runaway, random, all +2,");
        $display("all -2, all zero and mixed extremes");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
